// File: rtl/core/bpse_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the battery pack status evaluator.
// Used by the top level, the pipelined divider and the port checker.
package bpse_pkg;

  typedef enum logic [2:0] {
    CFG_BASE_LIMIT  = 3'd0,
    CFG_FLOOR_LIMIT = 3'd1,
    CFG_SOC_MIN     = 3'd2,
    CFG_TEMP_MAX    = 3'd3,
    CFG_CELL_MIN    = 3'd4,
    CFG_PACK_ENERGY = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    TS_VALID  = 2'd0,
    TS_IDLE   = 2'd1,
    TS_LOWPWR = 2'd2
  } tstat_e;

  localparam logic [15:0]       BaseLimitRst  = 16'd6000;
  localparam logic [15:0]       FloorLimitRst = 16'd500;
  localparam logic [6:0]        SocMinRst     = 7'd5;
  localparam logic signed [8:0] TempMaxRst    = 9'sd55;
  localparam logic [15:0]       CellMinRst    = 16'd2500;
  localparam logic [15:0]       PackEnergyRst = 16'd59850;

  // Divider geometry: socE * 3600000 over pack power.
  localparam int DivNumW = 45;
  localparam int DivDenW = 31;
  localparam int DivQW   = 32;

  // Reciprocals for constant division, exact over the value ranges in use.
  localparam logic [31:0] RecipRange = 32'd2748779070; // 2^36 / 25
  localparam logic [29:0] Recip20    = 30'd429496730;  // 2^33 / 20
  localparam logic [29:0] Recip15    = 30'd572662307;  // 2^33 / 15
  localparam logic [29:0] Recip300   = 30'd28633116;   // 2^33 / 300

  typedef struct packed {
    logic signed [8:0] cell_temp_c;
    logic [6:0]        health_pct;
    logic              is_charging;
    logic              is_safe;
    logic [26:0]       range_m;
    logic [15:0]       limit_da;
    tstat_e            tstat;
  } side_t;

endpackage

// File: rtl/core/bpse_div.sv
`timescale 1ns / 1ps
// Fully pipelined restoring divider, one quotient bit per stage.
// Carries a side_t payload alongside; depends on bpse_pkg.
module bpse_div import bpse_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic [DivNumW-1:0] dividend_i,
  input  logic [DivDenW-1:0] divisor_i,
  input  side_t              side_i,
  output logic               out_valid_o,
  output logic [DivQW-1:0]   quot_o,
  output side_t              side_o
);

  logic               vld_q  [DivQW];
  logic [DivDenW-1:0] rem_q  [DivQW];
  logic [DivQW-1:0]   lo_q   [DivQW];
  logic [DivDenW-1:0] den_q  [DivQW];
  side_t              side_q [DivQW];

  for (genvar s = 0; s < DivQW; s++) begin : g_stage
    logic               vld_in;
    logic [DivDenW-1:0] rem_in;
    logic [DivQW-1:0]   lo_in;
    logic [DivDenW-1:0] den_in;
    side_t              side_in;
    logic [DivDenW:0]   trial;
    logic               ge;

    if (s == 0) begin : g_head
      assign vld_in  = in_valid_i;
      assign rem_in  = DivDenW'(dividend_i[DivNumW-1:DivQW]);
      assign lo_in   = dividend_i[DivQW-1:0];
      assign den_in  = divisor_i;
      assign side_in = side_i;
    end else begin : g_body
      assign vld_in  = vld_q[s-1];
      assign rem_in  = rem_q[s-1];
      assign lo_in   = lo_q[s-1];
      assign den_in  = den_q[s-1];
      assign side_in = side_q[s-1];
    end

    // Shift in the next dividend bit and try the subtract.
    assign trial = {rem_in, lo_in[DivQW-1]};
    assign ge    = trial >= {1'b0, den_in};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else begin
        vld_q[s] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[s]  <= ge ? DivDenW'(trial - {1'b0, den_in}) : trial[DivDenW-1:0];
      lo_q[s]   <= {lo_in[DivQW-2:0], ge};
      den_q[s]  <= den_in;
      side_q[s] <= side_in;
    end
  end

  assign out_valid_o = vld_q[DivQW-1];
  assign quot_o      = lo_q[DivQW-1];
  assign side_o      = side_q[DivQW-1];

endmodule

// File: rtl/core/battery_pack_status_evaluator_top.sv
`timescale 1ns / 1ps
// Top level of the battery pack status evaluator: config registers, four
// front stages and the pipelined divider; depends on bpse_pkg and bpse_div.
//
// One status report is taken on every cycle that start is high; busy never
// rises. Each report yields one result, shown for a single cycle with done_o
// at the end of the pipeline, in order. The pipeline is four
// arithmetic stages followed by the 32-stage remaining-time divider, one
// quotient bit per stage. The receiver cannot stall the results.
module battery_pack_status_evaluator_top import bpse_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_idx_i,
  input  logic [15:0]         cfg_wdata_i,
  input  logic [15:0]         voltage_dv_i,
  input  logic signed [15:0]  current_da_i,
  input  logic [7:0]          charge_pct_i,
  input  logic [6:0]          health_pct_i,
  input  logic [7:0]          temp_raw_i,
  input  logic [7:0]          fault_num_i,
  input  logic [15:0]         min_cell_mv_i,
  output logic                done_o,
  output logic signed [8:0]   cell_temp_c_o,
  output logic [6:0]          health_out_pct_o,
  output logic                is_charging_o,
  output logic                is_safe_o,
  output logic [26:0]         range_m_o,
  output logic [15:0]         discharge_limit_da_o,
  output logic [1:0]          time_status_o,
  output logic [31:0]         remaining_time_s_o
);

  // Configuration registers
  logic [15:0]       base_q, floor_q, cell_min_q, energy_q;
  logic [6:0]        soc_min_q;
  logic signed [8:0] temp_max_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q     <= BaseLimitRst;
      floor_q    <= FloorLimitRst;
      soc_min_q  <= SocMinRst;
      temp_max_q <= TempMaxRst;
      cell_min_q <= CellMinRst;
      energy_q   <= PackEnergyRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_BASE_LIMIT:  base_q     <= cfg_wdata_i;
        CFG_FLOOR_LIMIT: floor_q    <= cfg_wdata_i;
        CFG_SOC_MIN:     soc_min_q  <= cfg_wdata_i[6:0];
        CFG_TEMP_MAX:    temp_max_q <= $signed(cfg_wdata_i[8:0]);
        CFG_CELL_MIN:    cell_min_q <= cfg_wdata_i;
        CFG_PACK_ENERGY: energy_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // Stage 1: decode, flags and first products
  logic [6:0]        soc_d;
  logic signed [8:0] temp_d;
  logic              soc_low_d, hot_d, cold_out_d, pos_d;

  assign soc_d      = (charge_pct_i > 8'd100) ? 7'd100 : charge_pct_i[6:0];
  assign temp_d     = $signed({1'b0, temp_raw_i}) - 9'sd40;
  assign soc_low_d  = soc_d < 7'd20;
  assign hot_d      = temp_d > 9'sd45;
  assign cold_out_d = temp_d >= 9'sd60;
  assign pos_d      = !current_da_i[15] && (current_da_i != 16'sd0);

  logic              v1_q;
  logic signed [8:0] temp1_q;
  logic [6:0]        health1_q;
  logic              chg1_q, safe1_q, soc_low1_q, hot1_q, cold_out1_q, pos1_q;
  logic [3:0]        tfac1_q;
  logic [22:0]       soce1_q;
  logic [20:0]       numa1_q;
  logic [30:0]       pwr1_q;

  always_ff @(posedge clk_i) begin
    temp1_q     <= temp_d;
    health1_q   <= health_pct_i;
    chg1_q      <= current_da_i[15];
    safe1_q     <= (fault_num_i == 8'd0) && (soc_d > soc_min_q) &&
                   (temp_d < temp_max_q) && (min_cell_mv_i > cell_min_q);
    soc_low1_q  <= soc_low_d;
    hot1_q      <= hot_d;
    cold_out1_q <= cold_out_d;
    pos1_q      <= pos_d;
    tfac1_q     <= 4'(9'sd60 - temp_d);
    soce1_q     <= 23'(soc_d) * 23'(energy_q);
    numa1_q     <= 21'(base_q) * 21'(soc_low_d ? soc_d[4:0] : 5'd1);
    pwr1_q      <= 31'(voltage_dv_i) * 31'(current_da_i[14:0]);
  end

  // Stage 2: range numerator, limit numerator, time dividend, status
  logic              v2_q;
  logic signed [8:0] temp2_q;
  logic [6:0]        health2_q;
  logic              chg2_q, safe2_q, soc_low2_q, hot2_q;
  logic [31:0]       xr2_q;
  logic [24:0]       num2_q;
  logic [44:0]       dvd2_q;
  logic [30:0]       pwr2_q;
  tstat_e            ts2_q;

  always_ff @(posedge clk_i) begin
    temp2_q    <= temp1_q;
    health2_q  <= health1_q;
    chg2_q     <= chg1_q;
    safe2_q    <= safe1_q;
    soc_low2_q <= soc_low1_q;
    hot2_q     <= hot1_q;
    xr2_q      <= 32'(soce1_q) * 32'd462;
    // At sixty degrees and above the derating factor is not positive: drop to zero.
    num2_q     <= cold_out1_q ? 25'd0 :
                  25'(numa1_q) * 25'(hot1_q ? tfac1_q : 4'd1);
    dvd2_q     <= 45'(soce1_q) * 45'd3600000;
    pwr2_q     <= pwr1_q;
    if (!pos1_q) begin
      ts2_q <= TS_IDLE;
    end else if (pwr1_q < 31'd10000) begin
      ts2_q <= TS_LOWPWR;
    end else begin
      ts2_q <= TS_VALID;
    end
  end

  // Stage 3: reciprocal multiplies for the constant divisions
  logic [29:0] recip_d;
  logic [54:0] lprod_d;
  logic [63:0] rprod_d;

  always_comb begin
    case ({soc_low2_q, hot2_q})
      2'b10:   recip_d = Recip20;
      2'b01:   recip_d = Recip15;
      2'b11:   recip_d = Recip300;
      default: recip_d = 30'd0;
    endcase
  end

  assign lprod_d = 55'(num2_q) * 55'(recip_d);
  assign rprod_d = 64'(xr2_q) * 64'(RecipRange);

  logic              v3_q;
  logic signed [8:0] temp3_q;
  logic [6:0]        health3_q;
  logic              chg3_q, safe3_q;
  logic [26:0]       range3_q;
  logic [15:0]       lq3_q;
  logic [44:0]       dvd3_q;
  logic [30:0]       pwr3_q;
  tstat_e            ts3_q;

  always_ff @(posedge clk_i) begin
    temp3_q   <= temp2_q;
    health3_q <= health2_q;
    chg3_q    <= chg2_q;
    safe3_q   <= safe2_q;
    range3_q  <= rprod_d[62:36];
    lq3_q     <= (soc_low2_q || hot2_q) ? lprod_d[48:33] : num2_q[15:0];
    dvd3_q    <= dvd2_q;
    pwr3_q    <= pwr2_q;
    ts3_q     <= ts2_q;
  end

  // Stage 4: floor the limit and pack the side payload
  logic        v4_q;
  side_t       side4_q;
  logic [44:0] dvd4_q;
  logic [30:0] pwr4_q;

  always_ff @(posedge clk_i) begin
    side4_q.cell_temp_c <= temp3_q;
    side4_q.health_pct  <= health3_q;
    side4_q.is_charging <= chg3_q;
    side4_q.is_safe     <= safe3_q;
    side4_q.range_m     <= range3_q;
    side4_q.limit_da    <= (lq3_q < floor_q) ? floor_q : lq3_q;
    side4_q.tstat       <= ts3_q;
    dvd4_q              <= dvd3_q;
    pwr4_q              <= pwr3_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= start && !busy;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  // Remaining time division
  logic              div_vld;
  logic [DivQW-1:0]  div_quot;
  side_t             div_side;

  bpse_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (v4_q),
    .dividend_i  (dvd4_q),
    .divisor_i   (pwr4_q),
    .side_i      (side4_q),
    .out_valid_o (div_vld),
    .quot_o      (div_quot),
    .side_o      (div_side)
  );

  assign done_o               = div_vld;
  assign cell_temp_c_o        = div_side.cell_temp_c;
  assign health_out_pct_o     = div_side.health_pct;
  assign is_charging_o        = div_side.is_charging;
  assign is_safe_o            = div_side.is_safe;
  assign range_m_o            = div_side.range_m;
  assign discharge_limit_da_o = div_side.limit_da;
  assign time_status_o        = div_side.tstat;

  always_comb begin
    case (div_side.tstat)
      TS_IDLE:   remaining_time_s_o = 32'd0;
      TS_LOWPWR: remaining_time_s_o = 32'd3600;
      default:   remaining_time_s_o = div_quot;
    endcase
  end

endmodule

// File: rtl/core/bpse_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the battery pack status evaluator, bound to the
// top level; depends on bpse_pkg.
module bpse_checker import bpse_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic        done_o,
  input logic        is_charging_o,
  input logic [1:0]  time_status_o,
  input logic [31:0] remaining_time_s_o
);

  a_fixed_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, 36))
    else $error("result without a transfer 36 cycles earlier");

  a_charging_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && is_charging_o) |-> (time_status_o == TS_IDLE))
    else $error("charging report with a time estimate");

  a_idle_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && time_status_o == TS_IDLE) |-> (remaining_time_s_o == 32'd0))
    else $error("idle report with nonzero time");

  a_lowpwr_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && time_status_o == TS_LOWPWR) |-> (remaining_time_s_o == 32'd3600))
    else $error("low power report without the fixed hour");

endmodule

bind battery_pack_status_evaluator_top bpse_checker u_bpse_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .start              (start),
  .busy               (busy),
  .done_o             (done_o),
  .is_charging_o      (is_charging_o),
  .time_status_o      (time_status_o),
  .remaining_time_s_o (remaining_time_s_o)
);
